FILE: rtl/core/aa_glyph_run_renderer_assert.svh
// Assertion macros shared by the glyph run renderer modules.
`ifndef AA_GLYPH_RUN_RENDERER_ASSERT_SVH
`define AA_GLYPH_RUN_RENDERER_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define AAGR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define AAGR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/aagr_pkg.sv
// Types, widths and codes shared by the glyph run renderer.
`default_nettype none
package aagr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WIN_W      = 10;
  localparam int COLOR_W    = 16;
  localparam int GX_W       = 12;
  localparam int GY_W       = 10;
  localparam int GW_W       = 10;
  localparam int CODE_W     = 8;
  localparam int LEN_W      = 6;
  localparam int CUR_X_W    = 13;
  localparam int CUR_Y_W    = 11;
  localparam int DIV_N_W    = 13;
  localparam int DIV_CNT_W  = 4;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam int DEF_SCREEN_HEIGHT = 240;

  localparam logic signed [CUR_X_W-1:0] X_MAX = 13'sd2047;
  localparam logic [CUR_Y_W-1:0]        Y_MAX = 11'd2047;

  localparam logic [WIN_W-1:0]   RST_WIN_LEFT  = 10'd0;
  localparam logic [WIN_W-1:0]   RST_WIN_RIGHT = 10'd319;
  localparam logic [COLOR_W-1:0] RST_FG        = 16'hFFFF;
  localparam logic [COLOR_W-1:0] RST_BG        = 16'h0000;
  localparam logic [COLOR_W-1:0] RST_HALF      = 16'h0000;
  localparam logic [COLOR_W-1:0] RST_QUARTER   = 16'h0000;

  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_RUN   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_LEFT  = 3'd0,
    REG_WIN_RIGHT = 3'd1,
    REG_FG        = 3'd2,
    REG_BG        = 3'd3,
    REG_HALF      = 3'd4,
    REG_QUARTER   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    LVL_BG      = 2'd0,
    LVL_QUARTER = 2'd1,
    LVL_HALF    = 2'd2,
    LVL_FG      = 2'd3
  } level_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_DRAW,
    S_DIV
  } state_t;

  typedef struct packed {
    logic begin_glyph;
    logic load_run;
    logic skip_move;
    logic div_start;
    logic div_commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic transparent;
    logic wraps;
    logic dead;
    logic len_zero;
    logic out_free;
    logic last_pix;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/aagr_div.sv
// Restoring divider, one quotient bit per cycle, for the transparent skip wrap.
`default_nettype none
`include "aa_glyph_run_renderer_assert.svh"
module aagr_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [aagr_pkg::DIV_N_W-1:0]  dividend,
  input  wire [aagr_pkg::GW_W-1:0]     divisor,
  output logic                         done,
  output logic [aagr_pkg::DIV_N_W-1:0] quotient,
  output logic [aagr_pkg::GW_W-1:0]    remainder
);
  import aagr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [GW_W-1:0]      rem_r, rem_nxt;
  logic [GW_W:0]        trial;
  logic [GW_W:0]        trial_diff;
  logic                 ge;

  assign trial      = {rem_r, quo_r[DIV_N_W-1]};
  assign ge         = trial >= {1'b0, divisor};
  assign trial_diff = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_N_W-2:0], ge};
      rem_nxt = ge ? trial_diff[GW_W-1:0] : trial[GW_W-1:0];
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  `AAGR_ASSERT_IMP(a_div_done_idle, done_r, !busy_r, "divider done while still busy")

endmodule
`default_nettype wire

FILE: rtl/core/aagr_ctrl.sv
// Controller state machine: sequences begin, skip, divide and pixel emission.
`default_nettype none
`include "aa_glyph_run_renderer_assert.svh"
module aagr_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire                 in_func,
  input  wire aagr_pkg::sts_t sts,
  output aagr_pkg::cmd_t      cmd
);
  import aagr_pkg::*;

  state_t state_r, state_nxt;
  logic   in_acc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_func == FUNC_RUN)) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (sts.transparent) begin
          state_nxt = sts.wraps ? S_DIV : S_IDLE;
        end else if (sts.dead || sts.len_zero) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DRAW;
        end
      end
      S_DRAW: begin
        if (sts.out_free && sts.last_pix) state_nxt = S_IDLE;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.begin_glyph = in_acc && (in_func == FUNC_BEGIN);
        cmd.load_run    = in_acc && (in_func == FUNC_RUN);
      end
      S_DECODE: begin
        cmd.skip_move = sts.transparent && !sts.wraps;
        cmd.div_start = sts.transparent && sts.wraps;
      end
      S_DRAW: begin
        cmd.emit = sts.out_free;
      end
      S_DIV: begin
        cmd.div_commit = sts.div_done;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `AAGR_ASSERT_NXT(a_div_wait, (state_r == S_DIV) && !sts.div_done, state_r == S_DIV,
                   "left divide wait early")
  `AAGR_ASSERT_NXT(a_run_end, cmd.emit && sts.last_pix, in_tready,
                   "no return to idle after last pixel")

endmodule
`default_nettype wire

FILE: rtl/core/aagr_dp.sv
// Datapath: config registers, cursor state, skip arithmetic and pixel output register.
`default_nettype none
`include "aa_glyph_run_renderer_assert.svh"
module aagr_dp #(
  parameter int SCREEN_HEIGHT = aagr_pkg::DEF_SCREEN_HEIGHT
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_wr_en,
  input  wire [aagr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [aagr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire [aagr_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire                             out_tready,
  output logic                            out_tvalid,
  output logic [aagr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  wire aagr_pkg::cmd_t             cmd,
  output aagr_pkg::sts_t                  sts
);
  import aagr_pkg::*;

  localparam logic [CUR_Y_W-1:0] SH = CUR_Y_W'(SCREEN_HEIGHT);

  // configuration
  logic [WIN_W-1:0]   win_left_r, win_right_r;
  logic [COLOR_W-1:0] fg_r, bg_r, half_r, quarter_r;

  // cursor and glyph geometry
  logic signed [CUR_X_W-1:0] cursor_x_r;
  logic [CUR_Y_W-1:0]        cursor_y_r;
  logic signed [GX_W-1:0]    row_start_r, row_end_r;
  logic [GW_W-1:0]           cell_w_r;

  logic [CODE_W-1:0] run_r;
  logic [LEN_W-1:0]  cnt_r;

  logic               out_valid_r;
  logic [GX_W-1:0]    out_x_r;
  logic [GY_W-1:0]    out_y_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_we_r, out_last_r;

  // input fields
  logic signed [GX_W-1:0] gx;
  logic [GY_W-1:0]        gy;
  logic [GW_W-1:0]        gw;
  logic [CODE_W-1:0]      gcode;

  assign gx    = in_tdata[GX_W-1:0];
  assign gy    = in_tdata[GX_W+GY_W-1:GX_W];
  assign gw    = in_tdata[GX_W+GY_W+GW_W-1:GX_W+GY_W];
  assign gcode = in_tdata[IN_DATA_W-1:GX_W+GY_W+GW_W];

  // begin: right edge, saturated
  logic [GW_W-1:0]           bw;
  logic signed [CUR_X_W-1:0] gx_ext, bw_ext, be;
  logic signed [GX_W-1:0]    be_sat;

  assign bw     = (gw == '0) ? GW_W'(1) : gw;
  assign gx_ext = {gx[GX_W-1], gx};
  assign bw_ext = {3'b000, bw};
  assign be     = gx_ext + bw_ext;
  assign be_sat = (be > X_MAX) ? X_MAX[GX_W-1:0] : be[GX_W-1:0];

  // run decode
  level_t           level;
  logic [LEN_W-1:0] len;

  assign level = level_t'(run_r[CODE_W-1:LEN_W]);
  assign len   = run_r[LEN_W-1:0];

  logic signed [CUR_X_W:0] x_ext, rs_ext, re_ext, x_skip, d_skip, xn;
  logic signed [CUR_X_W:0] wl_ext, wr_ext, len_ext;

  assign x_ext   = {cursor_x_r[CUR_X_W-1], cursor_x_r};
  assign rs_ext  = {{2{row_start_r[GX_W-1]}}, row_start_r};
  assign re_ext  = {{2{row_end_r[GX_W-1]}}, row_end_r};
  assign wl_ext  = {4'b0000, win_left_r};
  assign wr_ext  = {4'b0000, win_right_r};
  assign len_ext = {8'b0000_0000, len};
  assign x_skip  = x_ext + len_ext;
  assign d_skip  = x_skip - rs_ext;   // never negative
  assign xn      = x_ext + 14'sd1;

  // draw step
  logic               row_wrap, stop, we;
  logic [CUR_Y_W-1:0] yn;
  logic [COLOR_W-1:0] color;

  assign row_wrap = xn >= re_ext;
  assign yn       = cursor_y_r + CUR_Y_W'(1);
  assign stop     = row_wrap && (yn >= SH);
  assign we       = (x_ext >= wl_ext) && (x_ext < wr_ext);

  always_comb begin
    case (level)
      LVL_FG:      color = fg_r;
      LVL_HALF:    color = half_r;
      LVL_QUARTER: color = quarter_r;
      default:     color = bg_r;
    endcase
  end

  // divider for the transparent wrap
  logic                div_done;
  logic [DIV_N_W-1:0]  quo;
  logic [GW_W-1:0]     rem;
  logic [CUR_Y_W+2:0]  ysum;
  logic [CUR_Y_W-1:0]  y_wrap;
  logic signed [CUR_X_W-1:0] x_wrap;

  aagr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (d_skip[DIV_N_W-1:0]),
    .divisor   (cell_w_r),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  assign ysum   = {3'b000, cursor_y_r} + {1'b0, quo};
  assign y_wrap = (ysum > {3'b000, Y_MAX}) ? Y_MAX : ysum[CUR_Y_W-1:0];
  assign x_wrap = {row_start_r[GX_W-1], row_start_r} + $signed({3'b000, rem});

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    sts             = '0;
    sts.transparent = (level == LVL_BG) && (bg_r == fg_r);
    sts.wraps       = x_skip >= re_ext;
    sts.dead        = cursor_y_r >= SH;
    sts.len_zero    = (len == '0);
    sts.out_free    = out_free;
    sts.last_pix    = stop || (cnt_r == LEN_W'(1));
    sts.div_done    = div_done;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r  <= RST_WIN_LEFT;
      win_right_r <= RST_WIN_RIGHT;
      fg_r        <= RST_FG;
      bg_r        <= RST_BG;
      half_r      <= RST_HALF;
      quarter_r   <= RST_QUARTER;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIN_LEFT:  win_left_r  <= cfg_wdata[WIN_W-1:0];
        REG_WIN_RIGHT: win_right_r <= cfg_wdata[WIN_W-1:0];
        REG_FG:        fg_r        <= cfg_wdata;
        REG_BG:        bg_r        <= cfg_wdata;
        REG_HALF:      half_r      <= cfg_wdata;
        REG_QUARTER:   quarter_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // cursor state
  logic signed [CUR_X_W-1:0] cursor_x_nxt;
  logic [CUR_Y_W-1:0]        cursor_y_nxt;

  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    if (cmd.begin_glyph) begin
      cursor_x_nxt = gx_ext;
      cursor_y_nxt = {1'b0, gy};
    end else if (cmd.skip_move) begin
      cursor_x_nxt = x_skip[CUR_X_W-1:0];
    end else if (cmd.div_commit) begin
      cursor_x_nxt = x_wrap;
      cursor_y_nxt = y_wrap;
    end else if (cmd.emit) begin
      if (row_wrap) begin
        cursor_y_nxt = yn;
        // at the screen bottom the cursor stays past the right edge
        cursor_x_nxt = stop ? xn[CUR_X_W-1:0] : {row_start_r[GX_W-1], row_start_r};
      end else begin
        cursor_x_nxt = xn[CUR_X_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      row_start_r <= '0;
      row_end_r   <= '0;
      cell_w_r    <= GW_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      if (cmd.begin_glyph) begin
        row_start_r <= gx;
        row_end_r   <= be_sat;
        cell_w_r    <= bw;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_run) begin
      run_r <= gcode;
      cnt_r <= gcode[LEN_W-1:0];
    end else if (cmd.emit) begin
      cnt_r <= cnt_r - LEN_W'(1);
    end
    if (cmd.emit) begin
      out_x_r     <= cursor_x_r[GX_W-1:0];
      out_y_r     <= cursor_y_r[GY_W-1:0];
      out_color_r <= color;
      out_we_r    <= we;
      out_last_r  <= stop || (cnt_r == LEN_W'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_color_r, out_y_r, out_x_r};
  assign out_tuser  = out_we_r;
  assign out_tlast  = out_last_r;

  `AAGR_ASSERT_IMP(a_emit_on_screen, cmd.emit, cursor_y_r < SH,
                   "pixel emitted below screen bottom")
  `AAGR_ASSERT_IMP(a_emit_room, cmd.emit, out_free, "pixel emitted over a pending request")

endmodule
`default_nettype wire

FILE: rtl/core/aa_glyph_run_renderer.sv
// Top level of the run-length anti-aliased glyph renderer (RGB565 pixels).
//
// Input stream: in_tuser picks the item kind (0 begin glyph, 1 run byte).
// A begin request loads origin and width and produces no output. A run
// request passes a decode state, then one pixel per cycle while the output
// is not stalled, for its length (up to 63) or to the screen bottom; the
// input is held until the run is done. A transparent background run
// (foreground equal to background) only moves the cursor; when it wraps
// rows, the bit-serial divider computes the row and column after the skip.
// Output stream: one registered request per pixel, after the decode state;
// out_tlast marks the final pixel of a run, out_tuser the
// window write enable. A stalled receiver holds the pixel in the output
// register and the controller waits; nothing is dropped.
// The config port writes one register per cycle with cfg_wr_en; write only
// while no run is in progress.
// Reset (synchronous, rst_n low) restores register defaults and puts the
// cursor at the origin of a one-column glyph; no clearing pass is needed.
`default_nettype none
module aa_glyph_run_renderer #(
  parameter int SCREEN_HEIGHT = aagr_pkg::DEF_SCREEN_HEIGHT
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_wr_en,
  input  wire [aagr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [aagr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // glyph_x[11:0], glyph_y[21:12], glyph_width[31:22], run_code[39:32]
  input  wire [aagr_pkg::IN_DATA_W-1:0]   in_tdata,
  // func[0]
  input  wire                             in_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // pixel_x[11:0], pixel_y[21:12], pixel_color[37:22], zero[39:38]
  output logic [aagr_pkg::OUT_DATA_W-1:0] out_tdata,
  // write_enable[0]
  output logic                            out_tuser,
  output logic                            out_tlast
);
  import aagr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  aagr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  aagr_dp #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

FILE: sim/tb_aa_glyph_run_renderer.sv
// Self-checking testbench for the run-length anti-aliased glyph renderer.
`timescale 1ns / 100ps
module tb_aa_glyph_run_renderer;
  import aagr_pkg::*;

  localparam int SCREEN_H = DEF_SCREEN_HEIGHT;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 40;
  localparam int RANDOM_ITEMS    = 220;

  typedef struct {
    logic [GX_W-1:0]    x;
    logic [GY_W-1:0]    y;
    logic [COLOR_W-1:0] color;
    logic               we;
    logic               last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  // register mirror
  logic [WIN_W-1:0]   win_left, win_right;
  logic [COLOR_W-1:0] fg_col, bg_col, half_col, quarter_col;
  // cursor mirror
  int cur_x, cur_y, row_start, row_end, cell_w;

  pixel_t pending_pixels[$];
  int     mismatches;
  int     items_sent;
  int     sink_hold_cycles;
  bit     tx_idle_on;
  bit     rx_idle_on;

  aa_glyph_run_renderer #(.SCREEN_HEIGHT(SCREEN_H)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void reset_model();
    win_left    = RST_WIN_LEFT;
    win_right   = RST_WIN_RIGHT;
    fg_col      = RST_FG;
    bg_col      = RST_BG;
    half_col    = RST_HALF;
    quarter_col = RST_QUARTER;
    cur_x     = 0;
    cur_y     = 0;
    row_start = 0;
    row_end   = 0;
    cell_w    = 1;
  endfunction

  // Works out the pixels one accepted request produces and queues them.
  function automatic void render_item(input logic func, input logic [IN_DATA_W-1:0] d);
    int gx, w, e, len, x, y, span, px, py;
    level_t lvl;
    logic [COLOR_W-1:0] col;
    bit stop;
    pixel_t p;
    if (func == FUNC_BEGIN) begin
      gx = int'($signed(d[11:0]));
      w  = int'(d[31:22]);
      if (w == 0) w = 1;
      e = gx + w;
      if (e > int'(X_MAX)) e = int'(X_MAX);
      cur_x     = gx;
      cur_y     = int'(d[21:12]);
      row_start = gx;
      row_end   = e;
      cell_w    = w;
      return;
    end
    lvl = level_t'(d[39:38]);
    len = int'(d[37:32]);
    // transparent background: cursor moves, nothing drawn
    if (lvl == LVL_BG && bg_col == fg_col) begin
      x = cur_x + len;
      if (x >= row_end) begin
        span = x - row_start;
        y = cur_y + span / cell_w;
        if (y > int'(Y_MAX)) y = int'(Y_MAX);
        cur_y = y;
        x = span % cell_w + row_start;
      end
      cur_x = x;
      return;
    end
    case (lvl)
      LVL_FG:      col = fg_col;
      LVL_HALF:    col = half_col;
      LVL_QUARTER: col = quarter_col;
      default:     col = bg_col;
    endcase
    x = cur_x;
    y = cur_y;
    if (y >= SCREEN_H) return;
    for (int i = 0; i < len; i++) begin
      stop = 1'b0;
      px = x;
      py = y;
      x += 1;
      if (x >= row_end) begin
        y += 1;
        if (y >= SCREEN_H) stop = 1'b1;
        else x = row_start;
      end
      p.x     = px[GX_W-1:0];
      p.y     = py[GY_W-1:0];
      p.color = col;
      p.we    = (px >= int'(win_left)) && (px < int'(win_right));
      p.last  = stop || (i + 1 == len);
      pending_pixels.push_back(p);
      if (stop) break;
    end
    cur_x = x;
    cur_y = y;
  endfunction

  function automatic void check_pixel();
    pixel_t e;
    if (pending_pixels.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected pixel x=%0d y=%0d col=%h we=%b last=%b", $realtime,
                 $signed(out_tdata[11:0]), out_tdata[21:12], out_tdata[37:22],
                 out_tuser, out_tlast);
      mismatches++;
      return;
    end
    e = pending_pixels.pop_front();
    if (out_tdata[11:0] !== e.x || out_tdata[21:12] !== e.y ||
        out_tdata[37:22] !== e.color || out_tdata[39:38] !== 2'b00 ||
        out_tuser !== e.we || out_tlast !== e.last) begin
      if (mismatches < 10) begin
        $display("%0t: pixel mismatch exp x=%0d y=%0d col=%h we=%b last=%b",
                 $realtime, $signed(e.x), e.y, e.color, e.we, e.last);
        $display("    got x=%0d y=%0d col=%h pad=%b we=%b last=%b",
                 $signed(out_tdata[11:0]), out_tdata[21:12], out_tdata[37:22],
                 out_tdata[39:38], out_tuser, out_tlast);
      end
      mismatches++;
    end
  endfunction

  // request monitor: inputs first so a prediction is queued before its pixels
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_tvalid === 1'b1 && in_tready === 1'b1)
      render_item(in_tuser, in_tdata);
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
      check_pixel();
  end

  initial begin : pixel_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 6) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic func, input logic [IN_DATA_W-1:0] data);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= data;
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_begin(input logic [GX_W-1:0] gx, input logic [GY_W-1:0] gy,
                            input logic [GW_W-1:0] gw);
    logic [31:0] filler;
    filler = $urandom();
    send_item(FUNC_BEGIN, {filler[CODE_W-1:0], gw, gy, gx});
  endtask

  task automatic send_run(input logic [CODE_W-1:0] code);
    logic [31:0] filler;
    filler = $urandom();
    send_item(FUNC_RUN, {code, filler});
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    // begin and skip requests give no pixel but may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_WIN_LEFT:  win_left    = val[WIN_W-1:0];
      REG_WIN_RIGHT: win_right   = val[WIN_W-1:0];
      REG_FG:        fg_col      = val;
      REG_BG:        bg_col      = val;
      REG_HALF:      half_col    = val;
      REG_QUARTER:   quarter_col = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Only while idle. Also pokes an index past the list, which must be ignored.
  task automatic program_regs(input logic [WIN_W-1:0] left, input logic [WIN_W-1:0] right,
                              input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                              input logic [COLOR_W-1:0] half, input logic [COLOR_W-1:0] quarter);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(REG_WIN_LEFT, CFG_DATA_W'(left));
    write_reg(REG_SPARE, junk[CFG_DATA_W-1:0]);
    write_reg(REG_WIN_RIGHT, CFG_DATA_W'(right));
    write_reg(REG_FG, fg);
    write_reg(REG_BG, bg);
    write_reg(REG_HALF, half);
    write_reg(REG_QUARTER, quarter);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_reset_state();
    // no begin yet: one-column glyph at the origin, reset colours
    send_run({LVL_FG, 6'd3});
    send_run({LVL_FG, 6'd0});
    send_run({LVL_BG, 6'd0});
    send_run({LVL_BG, 6'd5});
    wait_idle();
  endtask

  task automatic test_field_extremes();
    program_regs(10'd0, 10'd319, 16'hF800, 16'h001F, 16'h07E0, 16'hAAAA);
    send_begin(-12'sd2048, 10'd0, 10'd0);        // zero width acts as one
    send_run({LVL_HALF, 6'd2});
    send_begin(12'sd2047, 10'd1023, 10'd1023);   // below the screen
    send_run(8'hFF);
    send_begin(12'sd2000, 10'd5, 10'd100);       // right edge saturates
    send_run({LVL_FG, 6'd63});
    send_begin(12'sd10, 10'd238, 10'd5);         // hits bottom mid-run
    send_run({LVL_QUARTER, 6'd63});
    send_run({LVL_HALF, 6'd63});
    send_begin(12'sd1, 10'd0, 10'd7);
    send_run({LVL_BG, 6'd63});
    wait_idle();
  endtask

  task automatic test_window_edges();
    program_regs(10'd1023, 10'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_begin(12'sd1000, 10'd10, 10'd40);
    send_run({LVL_FG, 6'd45});
    wait_idle();
    program_regs(10'd0, 10'd1023, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_begin(-12'sd3, 10'd20, 10'd1023);
    send_run({LVL_HALF, 6'd63});
    wait_idle();
  endtask

  task automatic test_transparent_skip();
    program_regs(10'd2, 10'd14, 16'h1234, 16'h1234, 16'h5A5A, 16'hC3C3);
    send_begin(12'sd5, 10'd3, 10'd10);
    send_run({LVL_BG, 6'd4});      // stays on the row
    send_run({LVL_BG, 6'd63});     // wraps several rows
    send_run({LVL_FG, 6'd4});
    send_run({LVL_BG, 6'd0});
    wait_idle();
  endtask

  task automatic random_glyph();
    logic [GX_W-1:0]   gx;
    logic [GY_W-1:0]   gy;
    logic [GW_W-1:0]   gw;
    logic [CODE_W-1:0] code;
    logic [63:0]       raw;
    int nruns;
    tx_idle_on = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 7) == 0) begin
      // noise: arbitrary requests, either kind
      repeat ($urandom_range(1, 3)) begin
        raw = {$urandom(), $urandom()};
        send_item(raw[40], raw[IN_DATA_W-1:0]);
      end
      return;
    end
    if ($urandom_range(0, 7) == 0) begin
      gx = GX_W'($urandom());
      gy = GY_W'($urandom());
      gw = GW_W'($urandom());
    end else begin
      gx = GX_W'($urandom_range(0, 360)) - GX_W'(20);
      gy = GY_W'($urandom_range(0, SCREEN_H + 5));
      gw = GW_W'($urandom_range(1, 24));
    end
    send_begin(gx, gy, gw);
    nruns = $urandom_range(1, 8);
    repeat (nruns) begin
      code[7:6] = 2'($urandom_range(0, 3));
      code[5:0] = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 12));
      send_run(code);
    end
  endtask

  task automatic test_random_glyphs();
    logic [COLOR_W-1:0] shared;
    int target;
    for (int phase = 0; phase < 4; phase++) begin
      shared = COLOR_W'($urandom());
      case (phase)
        0: program_regs(WIN_W'($urandom_range(0, 100)), WIN_W'($urandom_range(200, 1023)),
                        COLOR_W'($urandom()), COLOR_W'($urandom()),
                        COLOR_W'($urandom()), COLOR_W'($urandom()));
        1: program_regs(WIN_W'($urandom_range(0, 1023)), WIN_W'($urandom_range(0, 1023)),
                        shared, shared, COLOR_W'($urandom()), COLOR_W'($urandom()));
        2: program_regs(10'd0, 10'd1023, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        default: program_regs(10'd1023, 10'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'h5555);
      endcase
      target = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < target) random_glyph();
      wait_idle();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    program_regs(10'd0, 10'd319, 16'hFFFF, 16'h0000, 16'h8410, 16'h4208);
    tx_idle_on = 1'b0;
    send_begin(12'sd0, 10'd0, 10'd30);
    sink_hold_cycles = HOLD_OFF_CYCLES;
    repeat (8) send_run({LVL_FG, 6'd20});
    tx_idle_on = 1'b1;
    wait_idle();
  endtask

  initial begin : main
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = 1'b0;
    mismatches       = 0;
    items_sent       = 0;
    sink_hold_cycles = 0;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_field_extremes();
    test_window_edges();
    test_transparent_skip();
    test_random_glyphs();
    test_backpressure();
    wait_idle();

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
